// File: hdl/sla_pkg.sv
package sla_pkg;

  // Request limits and page rounding
  localparam int MAX_DIM   = 8192;
  localparam int PAGE_LOG  = 12;
  localparam int PAGE_BYTES = 1 << PAGE_LOG;

  // Field widths
  localparam int DIM_W   = 14;
  localparam int BPE_W   = 5;
  localparam int PITCH_W = 19;
  localparam int SIZE_W  = 32;
  localparam int BASE_W  = 24;

  // Internal widths
  localparam int AH_W    = DIM_W + 1;           // aligned height before range check
  localparam int PA_W    = 13;                  // pitch alignment in elements
  localparam int N_W     = 15;                  // width plus alignment minus one
  localparam int Q_W     = 12;                  // quotient of the round-up division
  localparam int PW_W    = PITCH_W + 1;         // pitch before range check
  localparam int PROD_W  = AH_W + PW_W;         // height times pitch
  localparam int RND_W   = PROD_W + 1;          // page rounded size

  // Divider pipeline
  localparam int DIV_STEP   = 3;
  localparam int DIV_STAGES = Q_W / DIV_STEP;

  // Register stages of each unit and the request-to-result latency
  localparam int DEC_STAGES  = 3;
  localparam int SIZE_STAGES = 4;
  localparam int LATENCY     = DEC_STAGES + DIV_STAGES + SIZE_STAGES;

  // Alignment constants
  localparam int PITCH_FALLBACK   = 512;
  localparam int BASE_FALLBACK    = 512;
  localparam int GROUP_SMALL      = 256;
  localparam int GROUP_LARGE      = 512;
  localparam int LINEAR_MIN_PITCH = 64;
  localparam int MICRO_MIN_PITCH  = 8;
  localparam int MICRO_HA_LOG     = 3;
  localparam int BANK_BASE_LOG    = 6;

  localparam logic [RND_W-1:0] PAGE_MASK = RND_W'(PAGE_BYTES - 1);

  // Tiling modes; any other code is macro tiled
  localparam logic [1:0] MODE_LINEAR = 2'd0;
  localparam logic [1:0] MODE_MICRO  = 2'd1;

  // Register map
  localparam logic REG_TILE_WORD  = 1'b0;
  localparam logic REG_INFO_VALID = 1'b1;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_BAD_WORD   = 2'd1,
    ST_ZERO_ALIGN = 2'd2,
    ST_OVERFLOW   = 2'd3
  } sla_status_t;

  // floor(512 / n) for n = 0..31, zero for n = 0. Smaller group quotients are shifts of it.
  localparam logic [9:0] G512_TABLE [32] = '{
    10'd0,   10'd512, 10'd256, 10'd170, 10'd128, 10'd102, 10'd85, 10'd73,
    10'd64,  10'd56,  10'd51,  10'd46,  10'd42,  10'd39,  10'd36, 10'd34,
    10'd32,  10'd30,  10'd28,  10'd26,  10'd25,  10'd24,  10'd23, 10'd22,
    10'd21,  10'd20,  10'd19,  10'd18,  10'd18,  10'd17,  10'd17, 10'd16
  };

  // Per-request data that rides along the divider
  typedef struct packed {
    sla_status_t          status;
    logic                 hw;
    logic [BPE_W-1:0]     bpe;
    logic [DIM_W-1:0]     w;
    logic [AH_W-1:0]      ah;
    logic                 dim_ovf;
    logic [BASE_W-1:0]    base;
  } sla_side_t;

endpackage

// File: hdl/sla_decode.sv
module sla_decode (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         accept,
  input  logic [13:0]                  width_px,
  input  logic [13:0]                  height_px,
  input  logic [4:0]                   bytes_per_element,
  input  logic [1:0]                   tiling_mode,
  input  logic                         hw_surface,
  input  logic [11:0]                  tile_word,
  input  logic                         tiling_info_valid,
  output logic                         out_valid,
  output sla_pkg::sla_side_t           out_side,
  output logic [sla_pkg::N_W-1:0]      out_num,
  output logic [sla_pkg::PA_W-1:0]     out_pa
);
  import sla_pkg::*;

  // Stage 1: captured request
  logic             v1;
  logic [DIM_W-1:0] w1;
  logic [DIM_W-1:0] h1;
  logic [BPE_W-1:0] bpe1;
  logic [1:0]       mode1;
  logic             hw1;

  // Stage 2: decoded alignments
  logic              v2;
  sla_status_t       status2;
  logic              hw2;
  logic              macro2;
  logic [DIM_W-1:0]  w2;
  logic [BPE_W-1:0]  bpe2;
  logic [AH_W-1:0]   ah2;
  logic              dim_ovf2;
  logic [PA_W-1:0]   pa2;
  logic [2:0]        ha_log2;
  logic [1:0]        ch_log2;
  logic [9:0]        base_lin2;
  logic [8:0]        bank_bpe2;

  // Decode logic
  logic [3:0]        cc;
  logic [3:0]        gc;
  logic [3:0]        banks;
  logic              bad;
  logic              zero;
  logic              macro;
  logic [9:0]        g_tab;
  logic [9:0]        gdiv;
  logic [6:0]        qm;
  logic [6:0]        qm1;
  logic [10:0]       mprod;
  logic [PA_W-1:0]   pa;
  logic [2:0]        ha_log;
  logic [AH_W-1:0]   ha_mask;
  logic [AH_W-1:0]   ah_round;
  logic [9:0]        base_lin;
  sla_status_t       status;

  // Base and numerator logic
  logic [17:0]       pa_bpe;
  logic [BASE_W-1:0] base_tile;
  logic [BASE_W-1:0] base_bank;
  logic [BASE_W-1:0] base;
  logic [N_W-1:0]    num;

  always_comb begin
    cc    = tile_word[3:0];
    gc    = tile_word[11:8];
    bad   = tiling_info_valid && (cc > 4'd3 || gc > 4'd1);
    banks = tiling_info_valid ? tile_word[7:4] : 4'd0;
    g_tab = G512_TABLE[bpe1];

    if (!tiling_info_valid) begin
      gdiv     = '0;
      qm       = '0;
      base_lin = 10'(BASE_FALLBACK);
    end else if (gc[0]) begin
      gdiv     = g_tab;
      qm       = 7'(g_tab >> 3);
      base_lin = 10'(GROUP_LARGE);
    end else begin
      gdiv     = g_tab >> 1;
      qm       = 7'(g_tab >> 4);
      base_lin = 10'(GROUP_SMALL);
    end

    qm1   = (qm == '0) ? 7'd1 : qm;
    mprod = 11'(qm1 * banks);

    case (mode1)
      MODE_LINEAR: begin
        macro  = 1'b0;
        ha_log = 3'(MICRO_HA_LOG);
        if (!tiling_info_valid) begin
          pa = PA_W'(PITCH_FALLBACK);
        end else if (gdiv > 10'(LINEAR_MIN_PITCH)) begin
          pa = PA_W'(gdiv);
        end else begin
          pa = PA_W'(LINEAR_MIN_PITCH);
        end
      end
      MODE_MICRO: begin
        macro  = 1'b0;
        ha_log = 3'(MICRO_HA_LOG);
        pa     = (gdiv > 10'(MICRO_MIN_PITCH)) ? PA_W'(gdiv) : PA_W'(MICRO_MIN_PITCH);
      end
      default: begin
        macro  = 1'b1;
        ha_log = 3'({1'b0, cc[1:0]}) + 3'(MICRO_HA_LOG);
        pa     = PA_W'({mprod, 3'b000});
      end
    endcase

    // Banks read as zero without valid tiling info, so this covers both macro cases
    zero = (bpe1 == '0) || (macro && banks == '0);

    if (bad) begin
      status = ST_BAD_WORD;
    end else if (zero) begin
      status = ST_ZERO_ALIGN;
    end else begin
      status = ST_OK;
    end

    ha_mask  = AH_W'((AH_W'(1) << ha_log) - AH_W'(1));
    ah_round = ({1'b0, h1} + ha_mask) & ~ha_mask;
  end

  always_comb begin
    pa_bpe    = 18'(pa2 * bpe2);
    base_tile = BASE_W'(pa_bpe) << ha_log2;
    base_bank = BASE_W'(bank_bpe2) << (5'(ch_log2) + 5'(BANK_BASE_LOG));
    if (macro2) begin
      base = (base_tile > base_bank) ? base_tile : base_bank;
    end else begin
      base = BASE_W'(base_lin2);
    end
    num = N_W'({1'b0, w2}) + N_W'(pa2) - N_W'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      v1        <= accept;
      v2        <= v1;
      out_valid <= v2;
    end
  end

  always_ff @(posedge clk) begin
    w1    <= width_px;
    h1    <= height_px;
    bpe1  <= bytes_per_element;
    mode1 <= tiling_mode;
    hw1   <= hw_surface;

    status2   <= status;
    hw2       <= hw1;
    macro2    <= macro;
    w2        <= w1;
    bpe2      <= bpe1;
    ah2       <= hw1 ? ah_round : {1'b0, h1};
    dim_ovf2  <= (w1 > DIM_W'(MAX_DIM)) || (h1 > DIM_W'(MAX_DIM));
    pa2       <= pa;
    ha_log2   <= ha_log;
    ch_log2   <= cc[1:0];
    base_lin2 <= base_lin;
    bank_bpe2 <= 9'(banks * bpe1);

    out_side.status  <= status2;
    out_side.hw      <= hw2;
    out_side.bpe     <= bpe2;
    out_side.w       <= w2;
    out_side.ah      <= ah2;
    out_side.dim_ovf <= dim_ovf2;
    out_side.base    <= base;
    out_num          <= num;
    out_pa           <= pa2;
  end

endmodule

// File: hdl/sla_div.sv
module sla_div (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  input  sla_pkg::sla_side_t           in_side,
  input  logic [sla_pkg::N_W-1:0]      in_num,
  input  logic [sla_pkg::PA_W-1:0]     in_div,
  output logic                         out_valid,
  output sla_pkg::sla_side_t           out_side,
  output logic [sla_pkg::Q_W-1:0]      out_quo,
  output logic [sla_pkg::PA_W-1:0]     out_div
);
  import sla_pkg::*;

  logic            vld  [DIV_STAGES];
  sla_side_t       side [DIV_STAGES];
  logic [N_W-1:0]  num  [DIV_STAGES];
  logic [PA_W-1:0] dv   [DIV_STAGES];
  logic [PA_W-1:0] rem  [DIV_STAGES];
  logic [Q_W-1:0]  quo  [DIV_STAGES];

  for (genvar s = 0; s < DIV_STAGES; s++) begin : g_stage
    logic            v_in;
    sla_side_t       side_in;
    logic [N_W-1:0]  num_in;
    logic [PA_W-1:0] d_in;
    logic [PA_W-1:0] rem_in;
    logic [Q_W-1:0]  quo_in;
    logic [PA_W-1:0] rem_out;
    logic [Q_W-1:0]  quo_out;

    if (s == 0) begin : g_first
      // Top bits of the numerator stay below the divisor, so start there
      assign v_in    = in_valid;
      assign side_in = in_side;
      assign num_in  = in_num;
      assign d_in    = in_div;
      assign rem_in  = PA_W'(in_num[N_W-1:Q_W]);
      assign quo_in  = '0;
    end else begin : g_next
      assign v_in    = vld[s-1];
      assign side_in = side[s-1];
      assign num_in  = num[s-1];
      assign d_in    = dv[s-1];
      assign rem_in  = rem[s-1];
      assign quo_in  = quo[s-1];
    end

    // Restoring division, one quotient bit per step
    always_comb begin
      logic [PA_W:0] t;
      logic [PA_W-1:0] r;
      logic [Q_W-1:0] q;
      r = rem_in;
      q = quo_in;
      for (int j = 0; j < DIV_STEP; j++) begin
        t = {r, num_in[Q_W-1-s*DIV_STEP-j]};
        if (t >= {1'b0, d_in}) begin
          r = PA_W'(t - {1'b0, d_in});
          q[Q_W-1-s*DIV_STEP-j] = 1'b1;
        end else begin
          r = t[PA_W-1:0];
        end
      end
      rem_out = r;
      quo_out = q;
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[s] <= 1'b0;
      end else begin
        vld[s] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      side[s] <= side_in;
      num[s]  <= num_in;
      dv[s]   <= d_in;
      rem[s]  <= rem_out;
      quo[s]  <= quo_out;
    end
  end

  assign out_valid = vld[DIV_STAGES-1];
  assign out_side  = side[DIV_STAGES-1];
  assign out_quo   = quo[DIV_STAGES-1];
  assign out_div   = dv[DIV_STAGES-1];

endmodule

// File: hdl/sla_size.sv
module sla_size (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  input  sla_pkg::sla_side_t           in_side,
  input  logic [sla_pkg::Q_W-1:0]      in_quo,
  input  logic [sla_pkg::PA_W-1:0]     in_div,
  output logic                         done,
  output logic [18:0]                  pitch_bytes,
  output logic [13:0]                  padded_height,
  output logic [31:0]                  size_bytes,
  output logic [23:0]                  base_align_bytes,
  output logic [1:0]                   status
);
  import sla_pkg::*;

  // Stage a: aligned width
  logic            va;
  sla_side_t       side_a;
  logic [N_W-1:0]  aw;
  // Stage b: pitch
  logic            vb;
  sla_side_t       side_b;
  logic [PW_W-1:0] pitch_b;
  // Stage c: height times pitch
  logic            vc;
  sla_side_t       side_c;
  logic [PW_W-1:0] pitch_c;
  logic [PROD_W-1:0] prod_c;

  logic [PA_W+Q_W-1:0] quo_div;
  logic [RND_W-1:0]    rounded;
  logic [RND_W-1:0]    size_r;
  logic                ovf;

  logic [PITCH_W-1:0]  pitch_next;
  logic [DIM_W-1:0]    height_next;
  logic [SIZE_W-1:0]   size_next;
  logic [BASE_W-1:0]   base_next;
  sla_status_t         status_next;

  assign quo_div = (PA_W+Q_W)'(in_quo * in_div);

  always_comb begin
    rounded = {1'b0, prod_c} + PAGE_MASK;
    size_r  = rounded & ~PAGE_MASK;
    ovf     = side_c.dim_ovf || pitch_c[PITCH_W] || side_c.ah[DIM_W]
              || (size_r[RND_W-1:SIZE_W] != '0);

    case (side_c.status)
      ST_BAD_WORD, ST_ZERO_ALIGN: begin
        pitch_next  = '0;
        height_next = '0;
        size_next   = '0;
        base_next   = '0;
        status_next = side_c.status;
      end
      default: begin
        base_next = side_c.base;
        if (ovf) begin
          pitch_next  = '1;
          height_next = '1;
          size_next   = '1;
          status_next = ST_OVERFLOW;
        end else begin
          pitch_next  = pitch_c[PITCH_W-1:0];
          height_next = side_c.ah[DIM_W-1:0];
          size_next   = size_r[SIZE_W-1:0];
          status_next = ST_OK;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      va   <= 1'b0;
      vb   <= 1'b0;
      vc   <= 1'b0;
      done <= 1'b0;
    end else begin
      va   <= in_valid;
      vb   <= va;
      vc   <= vb;
      done <= vc;
    end
  end

  always_ff @(posedge clk) begin
    side_a  <= in_side;
    aw      <= in_side.hw ? quo_div[N_W-1:0] : N_W'(in_side.w);
    side_b  <= side_a;
    pitch_b <= PW_W'(aw * side_a.bpe);
    side_c  <= side_b;
    pitch_c <= pitch_b;
    prod_c  <= PROD_W'(side_b.ah * pitch_b);

    pitch_bytes      <= pitch_next;
    padded_height    <= height_next;
    size_bytes       <= size_next;
    base_align_bytes <= base_next;
    status           <= status_next;
  end

  a_error_zeroes: assert property (@(posedge clk) disable iff (rst)
    done && (status == ST_BAD_WORD || status == ST_ZERO_ALIGN)
    |-> pitch_bytes == '0 && padded_height == '0 && size_bytes == '0
        && base_align_bytes == '0)
    else $error("error result carries nonzero fields");

  a_overflow_ones: assert property (@(posedge clk) disable iff (rst)
    done && status == ST_OVERFLOW
    |-> (&pitch_bytes) && (&padded_height) && (&size_bytes))
    else $error("overflow result not saturated");

  a_page_rounded: assert property (@(posedge clk) disable iff (rst)
    done && status == ST_OK |-> size_bytes[PAGE_LOG-1:0] == '0)
    else $error("size not rounded to a page");

endmodule

// File: hdl/surface_layout_alignment_core.sv
// Surface layout and alignment core. A request (width, height, bytes per
// element, tiling mode, hardware flag) is taken on any cycle with start high;
// busy stays low, since the pipeline never stalls, so one request can enter
// every clock. Each answer is shown for a single cycle with done high:
// row pitch, aligned height, size rounded up to a 4096-byte page, base
// alignment and a status code. The pipeline is built from three decode
// stages, a four-stage round-up divider (three quotient bits per stage)
// and four stages of multiply, page rounding and range checks. The
// receiver must take each result in its done cycle; there is no back pressure.
// The tile word and its valid flag sit behind the APB port (tile word at
// byte address 0, valid flag at 4) and are to be written only while no
// request is in flight.

module surface_layout_alignment_core (
  input  logic        clk,
  input  logic        rst,
  // Request channel
  input  logic        start,
  output logic        busy,
  input  logic [13:0] width_px,
  input  logic [13:0] height_px,
  input  logic [4:0]  bytes_per_element,
  input  logic [1:0]  tiling_mode,
  input  logic        hw_surface,
  // Result channel
  output logic        done,
  output logic [18:0] pitch_bytes,
  output logic [13:0] padded_height,
  output logic [31:0] size_bytes,
  output logic [23:0] base_align_bytes,
  output logic [1:0]  status,
  // Configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import sla_pkg::*;

  logic [11:0] tile_word;
  logic        tiling_info_valid;
  logic        accept;
  logic        cfg_write;

  logic               dec_valid;
  sla_side_t          dec_side;
  logic [N_W-1:0]     dec_num;
  logic [PA_W-1:0]    dec_pa;

  logic               div_valid;
  sla_side_t          div_side;
  logic [Q_W-1:0]     div_quo;
  logic [PA_W-1:0]    div_div;

  // No back pressure anywhere in the pipeline
  assign busy   = 1'b0;
  assign pready = 1'b1;
  assign accept = start && !busy;

  // APB registers; word index is the address bit above the byte offset
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      tile_word         <= '0;
      tiling_info_valid <= 1'b0;
    end else if (cfg_write) begin
      case (paddr[2])
        REG_TILE_WORD:  tile_word         <= pwdata[11:0];
        REG_INFO_VALID: tiling_info_valid <= pwdata[0];
        default:        tile_word         <= tile_word;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_TILE_WORD:  prdata = {20'd0, tile_word};
      REG_INFO_VALID: prdata = {31'd0, tiling_info_valid};
      default:        prdata = '0;
    endcase
  end

  // Decode the tile word, pick pitch/height/base alignments, align the height of hardware surfaces
  sla_decode u_decode (
    .clk               (clk),
    .rst               (rst),
    .accept            (accept),
    .width_px          (width_px),
    .height_px         (height_px),
    .bytes_per_element (bytes_per_element),
    .tiling_mode       (tiling_mode),
    .hw_surface        (hw_surface),
    .tile_word         (tile_word),
    .tiling_info_valid (tiling_info_valid),
    .out_valid         (dec_valid),
    .out_side          (dec_side),
    .out_num           (dec_num),
    .out_pa            (dec_pa)
  );

  // Round the width up to the pitch alignment, which need not be a power of two
  sla_div u_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (dec_valid),
    .in_side   (dec_side),
    .in_num    (dec_num),
    .in_div    (dec_pa),
    .out_valid (div_valid),
    .out_side  (div_side),
    .out_quo   (div_quo),
    .out_div   (div_div)
  );

  // Pitch, size, page rounding, range checks and the result register
  sla_size u_size (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (div_valid),
    .in_side          (div_side),
    .in_quo           (div_quo),
    .in_div           (div_div),
    .done             (done),
    .pitch_bytes      (pitch_bytes),
    .padded_height    (padded_height),
    .size_bytes       (size_bytes),
    .base_align_bytes (base_align_bytes),
    .status           (status)
  );

  a_fixed_latency: assert property (@(posedge clk) disable iff (rst)
    accept |-> ##LATENCY done)
    else $error("request did not produce a result on time");

  a_no_spurious_done: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(accept, LATENCY))
    else $error("result without a matching request");

endmodule
